>>> hw/rtl/sjis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sjis_pkg: shared types and constants for the SJIS to ISO-2022-JP converter
// Beat structs, the character-set mode type and the per-item command word
// that travels from the classifier to the byte sequencer.
// -----------------------------------------------------------------------------
package sjis_pkg;

  // character-set mode of the output stream
  typedef enum logic [1:0] {
    MODE_ROMAN = 2'd0,
    MODE_X0208 = 2'd1,
    MODE_KANA  = 2'd2
  } mode_t;

  // input beat
  typedef struct packed {
    logic       kind;       // 0 = data byte, 1 = flush
    logic [7:0] data_byte;
  } in_item_t;

  // output beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // one queued command: optional escape, then zero to two character bytes
  typedef struct packed {
    logic       esc;        // emit escape sequence for esc_mode first
    mode_t      esc_mode;
    logic [1:0] nchar;      // character bytes that follow (0..2)
    logic [7:0] b0;
    logic [7:0] b1;
  } cmd_t;

  localparam logic       KIND_DATA  = 1'b0;
  localparam logic       KIND_FLUSH = 1'b1;

  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] ESC_DOLLAR = 8'h24;
  localparam logic [7:0] ESC_PAREN  = 8'h28;
  localparam logic [7:0] FINAL_B    = 8'h42;
  localparam logic [7:0] FINAL_I    = 8'h49;
  localparam logic [7:0] FINAL_J    = 8'h4A;

  localparam logic [7:0] LEAD_OFF_LO = 8'h70;
  localparam logic [7:0] LEAD_OFF_HI = 8'hB0;
  localparam logic [7:0] TRAIL_SPLIT = 8'h9F;
  localparam logic [7:0] KANA_MASK   = 8'h7F;
  localparam logic [7:0] TRAIL_SUB_A = 8'h20;
  localparam logic [7:0] TRAIL_SUB_B = 8'h1F;
  localparam logic [7:0] TRAIL_SUB_C = 8'h7E;
  localparam logic [7:0] HIGH_BIT    = 8'h80;
  localparam logic [7:0] NBSP_BYTE   = 8'hA0;
  localparam logic [7:0] LEAD_HI_LO  = 8'hE0;
  localparam logic [7:0] USER_LO     = 8'hF0;

  localparam logic [1:0] NCHAR_NONE = 2'd0;
  localparam logic [1:0] NCHAR_ONE  = 2'd1;
  localparam logic [1:0] NCHAR_TWO  = 2'd2;

endpackage : sjis_pkg
`default_nettype wire

>>> hw/rtl/sjis_front.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sjis_front: input classifier
// Holds mode and pending lead byte, decodes each input beat into a command
// word and pushes it to the queue when the beat produces output bytes.
// -----------------------------------------------------------------------------
module sjis_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              acc,        // input beat accepted
  input  sjis_pkg::in_item_t item,
  output logic             push,
  output sjis_pkg::cmd_t   cmd
);
  import sjis_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic [7:0] lead_r, lead_nxt;
  logic       lead_vld_r, lead_vld_nxt;

  logic [7:0] b;
  mode_t      want;
  logic [1:0] nchar;
  logic [7:0] first, second, off, diff;
  logic [7:0] dbl;

  assign b = item.data_byte;

  // pair arithmetic on the held lead and the incoming trail
  always_comb begin
    off  = (lead_r >= LEAD_HI_LO) ? LEAD_OFF_HI : LEAD_OFF_LO;
    diff = lead_r - off;
    dbl  = {diff[6:0], 1'b0};
    if (lead_r >= USER_LO) begin
      first  = lead_r;
      second = b;
    end else if (b < TRAIL_SPLIT) begin
      first  = dbl[7:0] - 8'd1;
      second = (b > KANA_MASK) ? (b - TRAIL_SUB_A) : (b - TRAIL_SUB_B);
    end else begin
      first  = dbl[7:0];
      second = b - TRAIL_SUB_C;
    end
  end

  // classify the beat and update state
  always_comb begin
    mode_nxt     = mode_r;
    lead_nxt     = lead_r;
    lead_vld_nxt = lead_vld_r;
    want         = mode_r;
    nchar        = NCHAR_NONE;
    cmd.b0       = b;
    cmd.b1       = second;
    priority if (item.kind == KIND_FLUSH) begin
      want = MODE_ROMAN;
    end else if (lead_vld_r) begin
      want         = MODE_X0208;
      nchar        = NCHAR_TWO;
      cmd.b0       = first;
      lead_nxt     = 8'h00;
      lead_vld_nxt = 1'b0;
    end else if (b < HIGH_BIT || b == NBSP_BYTE) begin
      want  = MODE_ROMAN;
      nchar = NCHAR_ONE;
    end else if (b > NBSP_BYTE && b < LEAD_HI_LO) begin
      want   = MODE_KANA;
      nchar  = NCHAR_ONE;
      cmd.b0 = b & KANA_MASK;
    end else begin
      lead_nxt     = b;
      lead_vld_nxt = 1'b1;
    end
    if (nchar != NCHAR_NONE || item.kind == KIND_FLUSH) begin
      mode_nxt = want;
    end
    cmd.esc      = (nchar != NCHAR_NONE || item.kind == KIND_FLUSH) && (mode_r != want);
    cmd.esc_mode = want;
    cmd.nchar    = nchar;
    push         = acc && (cmd.esc || nchar != NCHAR_NONE);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_ROMAN;
      lead_r     <= 8'h00;
      lead_vld_r <= 1'b0;
    end else if (acc) begin
      mode_r     <= mode_nxt;
      lead_r     <= lead_nxt;
      lead_vld_r <= lead_vld_nxt;
    end
  end

endmodule : sjis_front
`default_nettype wire

>>> hw/rtl/sjis_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sjis_queue: command queue
// Small register FIFO that decouples the classifier from the byte sequencer.
// -----------------------------------------------------------------------------
module sjis_queue #(
  parameter int DEPTH = 4
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  sjis_pkg::cmd_t wr_cmd,
  output logic           full,
  input  wire            pop,
  output sjis_pkg::cmd_t head,
  output logic           empty
);
  import sjis_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          entry_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = entry_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= wr_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule : sjis_queue
`default_nettype wire

>>> hw/rtl/sjis_back.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sjis_back: byte sequencer
// Walks the head command one byte per cycle unless stalled (escape, then
// characters) into the output register and pops it after its final byte.
// -----------------------------------------------------------------------------
module sjis_back (
  input  wire                clk,
  input  wire                rst_n,
  input  sjis_pkg::cmd_t     head,
  input  wire                empty,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_stall,
  output sjis_pkg::out_item_t out_item
);
  import sjis_pkg::*;

  logic [2:0] pos_r;
  logic       vld_r;
  out_item_t  item_r;

  logic [2:0] v;
  logic [7:0] byte_sel;
  logic       is_last, load;

  // byte at the current position; v counts escape bytes 0..2, chars 3..4
  always_comb begin
    v = head.esc ? pos_r : pos_r + 3'd3;
    unique case (v)
      3'd0: byte_sel = ESC_BYTE;
      3'd1: byte_sel = (head.esc_mode == MODE_X0208) ? ESC_DOLLAR : ESC_PAREN;
      3'd2: begin
        unique case (head.esc_mode)
          MODE_X0208: byte_sel = FINAL_B;
          MODE_KANA:  byte_sel = FINAL_I;
          default:    byte_sel = FINAL_J;
        endcase
      end
      3'd3:    byte_sel = head.b0;
      default: byte_sel = head.b1;
    endcase
    is_last = (v == 3'd2 && head.nchar == NCHAR_NONE) ||
              (v == 3'd3 && head.nchar == NCHAR_ONE) || (v >= 3'd4);
    load    = !empty && (!vld_r || !out_stall);
    pop     = load && is_last;
  end

  // position within the command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 3'd0;
      vld_r <= 1'b0;
    end else begin
      if (load) begin
        pos_r <= is_last ? 3'd0 : pos_r + 3'd1;
        vld_r <= 1'b1;
      end else if (!out_stall) begin
        vld_r <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.out_byte <= byte_sel;
      item_r.last     <= is_last;
    end
  end

  assign out_valid = vld_r;
  assign out_item  = item_r;

endmodule : sjis_back
`default_nettype wire

>>> hw/rtl/sjis_to_iso2022jp_converter_unit.sv
// A byte-producing input beat writes the queue at its accepting edge and its
// first byte then enters the output register. Throughput: one input beat per
// cycle while the command queue has room; the sequencer sends one output byte
// per cycle while the output is not stalled, so a beat with an escape gives
// three to five output bytes. Reset (rst_n low, synchronous) returns to Roman
// mode with no held lead byte and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sjis_to_iso2022jp_converter_unit: Shift-JIS to ISO-2022-JP stream converter
// Classifier front end, command queue and byte sequencer back end.
// -----------------------------------------------------------------------------
module sjis_to_iso2022jp_converter_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  sjis_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output sjis_pkg::out_item_t out_item
);
  import sjis_pkg::*;

  logic acc, push, full, pop, empty;
  cmd_t wr_cmd, head;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  sjis_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (in_item),
    .push  (push),
    .cmd   (wr_cmd)
  );

  sjis_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .full   (full),
    .pop    (pop),
    .head   (head),
    .empty  (empty)
  );

  sjis_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule : sjis_to_iso2022jp_converter_unit
`default_nettype wire

>>> hw/rtl/sjis_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sjis_checker: port-level checks for the converter
// Output hold under stall, and clean channel state coming out of reset.
// -----------------------------------------------------------------------------
module sjis_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input sjis_pkg::in_item_t  in_item,
  input wire                 out_valid,
  input wire                 out_stall,
  input sjis_pkg::out_item_t out_item
);
  import sjis_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output beat changed under stall");

  // output register is empty right after reset
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // queue is empty right after reset, so input is not stalled
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule : sjis_checker

bind sjis_to_iso2022jp_converter_unit sjis_checker u_sjis_checker (.*);
`default_nettype wire

>>> dv/tb_sjis_to_iso2022jp_converter_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_sjis_to_iso2022jp_converter_unit: stream test of the SJIS to JIS converter
// Drives Shift-JIS beats and flushes through the valid/stall input channel.
// A local predictor tracks the output mode and the held lead byte. The checker
// compares every output beat, byte and last flag, against the oldest predicted
// byte. Random gaps on both sides and one long receiver hold-off fill the
// queue. Directed corner bytes, a backpressure burst, then a random mixed stream.
// -----------------------------------------------------------------------------
module tb_sjis_to_iso2022jp_converter_unit;
  import sjis_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // predicted output bytes, oldest first
  out_item_t  iso_bytes_q[$];
  // bytes produced by one input beat while predicting
  logic [7:0] beat_bytes[$];

  // predictor state
  mode_t      jis_mode;
  logic [7:0] held_lead;
  logic       lead_held;

  int cycle_count = 0;
  int err_count   = 0;
  bit tx_idle_en  = 1'b1;
  bit rx_idle_en  = 1'b1;
  bit hold_req    = 1'b0;

  sjis_to_iso2022jp_converter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // queue the escape sequence when the character set changes
  function automatic void enter_mode(input mode_t want);
    if (jis_mode != want) begin
      beat_bytes.push_back(ESC_BYTE);
      case (want)
        MODE_X0208: begin
          beat_bytes.push_back(ESC_DOLLAR);
          beat_bytes.push_back(FINAL_B);
        end
        MODE_KANA: begin
          beat_bytes.push_back(ESC_PAREN);
          beat_bytes.push_back(FINAL_I);
        end
        default: begin
          beat_bytes.push_back(ESC_PAREN);
          beat_bytes.push_back(FINAL_J);
        end
      endcase
      jis_mode = want;
    end
  endfunction

  function automatic void predict_conversion(input in_item_t beat);
    logic [7:0] b;
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] off;
    out_item_t  ob;
    b = beat.data_byte;
    beat_bytes.delete();
    if (beat.kind == KIND_FLUSH) begin
      // back to Roman, the held lead stays
      enter_mode(MODE_ROMAN);
    end else if (lead_held) begin
      lead_held = 1'b0;
      enter_mode(MODE_X0208);
      if (held_lead >= USER_LO) begin
        // user-defined pair goes out as is
        first  = held_lead;
        second = b;
      end else begin
        off   = (held_lead >= LEAD_HI_LO) ? LEAD_OFF_HI : LEAD_OFF_LO;
        first = held_lead - off;
        first = {first[6:0], 1'b0};
        if (b < TRAIL_SPLIT) begin
          first  = first - 8'd1;
          second = (b >= HIGH_BIT) ? b - TRAIL_SUB_A : b - TRAIL_SUB_B;
        end else begin
          second = b - TRAIL_SUB_C;
        end
      end
      held_lead = 8'h00;
      beat_bytes.push_back(first);
      beat_bytes.push_back(second);
    end else if (b < HIGH_BIT || b == NBSP_BYTE) begin
      enter_mode(MODE_ROMAN);
      beat_bytes.push_back(b);
    end else if (b > NBSP_BYTE && b < LEAD_HI_LO) begin
      enter_mode(MODE_KANA);
      beat_bytes.push_back(b & KANA_MASK);
    end else begin
      held_lead = b;
      lead_held = 1'b1;
    end
    foreach (beat_bytes[i]) begin
      ob.out_byte = beat_bytes[i];
      ob.last     = (i == beat_bytes.size() - 1);
      iso_bytes_q.push_back(ob);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  always @(posedge clk) begin : out_check
    out_item_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (iso_bytes_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte=%h last=%b",
                                  out_item.out_byte, out_item.last));
      end else begin
        exp_beat = iso_bytes_q.pop_front();
        if (out_item.out_byte !== exp_beat.out_byte)
          report_mismatch($sformatf("out_byte got %h exp %h",
                                    out_item.out_byte, exp_beat.out_byte));
        if (out_item.last !== exp_beat.last)
          report_mismatch($sformatf("last got %b exp %b (byte %h)",
                                    out_item.last, exp_beat.last, exp_beat.out_byte));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver stall, including the long hold-off on request
  initial begin : rx_stall_gen
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap(1'b1);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one input beat; valid stays high into the next call when there is no gap
  task automatic send_beat(input logic kind, input logic [7:0] data);
    int       gap;
    in_item_t beat;
    gap            = pick_gap(tx_idle_en);
    beat.kind      = kind;
    beat.data_byte = data;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    do @(posedge clk); while (in_stall);
    predict_conversion(beat);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // byte-class edges, pair arithmetic branches, flush cases
  task automatic test_directed_cases();
    send_beat(KIND_DATA, 8'h00);
    send_beat(KIND_DATA, 8'h7F);
    send_beat(KIND_DATA, 8'hA0);
    send_beat(KIND_DATA, 8'hA1);   // into kana
    send_beat(KIND_DATA, 8'hDF);
    send_beat(KIND_FLUSH, 8'h00);  // kana back to Roman
    send_beat(KIND_FLUSH, 8'h55);  // already Roman, nothing out
    send_beat(KIND_DATA, 8'h81);   // low trail
    send_beat(KIND_DATA, 8'h40);
    send_beat(KIND_DATA, 8'h9F);   // trail between 0x80 and 0x9E
    send_beat(KIND_DATA, 8'h80);
    send_beat(KIND_DATA, 8'hE0);   // high trail
    send_beat(KIND_DATA, 8'h9F);
    send_beat(KIND_DATA, 8'hEF);
    send_beat(KIND_DATA, 8'hFC);
    send_beat(KIND_DATA, 8'hF0);   // user-defined pairs
    send_beat(KIND_DATA, 8'hFF);
    send_beat(KIND_DATA, 8'hFF);
    send_beat(KIND_DATA, 8'h00);
    send_beat(KIND_DATA, 8'h80);   // lead held across a flush
    send_beat(KIND_FLUSH, 8'hFF);
    send_beat(KIND_DATA, 8'h7E);
    send_beat(KIND_DATA, 8'h41);
    send_beat(KIND_DATA, 8'h9F);   // kana-looking trail byte
    send_beat(KIND_DATA, 8'hA5);
  endtask

  // long receiver hold while the sender keeps pushing escape-heavy beats
  task automatic test_queue_backpressure();
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    for (int i = 0; i < 10; i++) begin
      send_beat(KIND_DATA, 8'($urandom_range(8'hA1, 8'hDF)));
      send_beat(KIND_DATA, 8'($urandom_range(8'h81, 8'h9F)));
      send_beat(KIND_DATA, 8'($urandom_range(8'h40, 8'hFC)));
      send_beat(KIND_DATA, 8'($urandom_range(8'h00, 8'h7F)));
    end
    tx_idle_en = 1'b1;
  endtask

  // mostly well-formed text with random content, plus flushes and noise
  task automatic test_random_stream(input int n_items);
    int         sent;
    int         next_toggle;
    int         pick;
    logic [7:0] lead;
    sent        = 0;
    next_toggle = 0;
    while (sent < n_items) begin
      // switch idling on and off in stretches
      if (sent >= next_toggle) begin
        tx_idle_en  = ($urandom_range(0, 2) != 0);
        rx_idle_en  = ($urandom_range(0, 2) != 0);
        next_toggle = sent + 64;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        if ($urandom_range(0, 15) == 0) send_beat(KIND_DATA, NBSP_BYTE);
        else send_beat(KIND_DATA, 8'($urandom_range(8'h00, 8'h7F)));
        sent++;
      end else if (pick < 45) begin
        send_beat(KIND_DATA, 8'($urandom_range(8'hA1, 8'hDF)));
        sent++;
      end else if (pick < 75) begin
        if ($urandom_range(0, 1) != 0) lead = 8'($urandom_range(8'h81, 8'h9F));
        else lead = 8'($urandom_range(8'hE0, 8'hEF));
        send_beat(KIND_DATA, lead);
        send_beat(KIND_DATA, 8'($urandom_range(8'h40, 8'hFC)));
        sent += 2;
      end else if (pick < 82) begin
        send_beat(KIND_DATA, 8'($urandom_range(8'hF0, 8'hFF)));
        send_beat(KIND_DATA, 8'($urandom_range(0, 255)));
        sent += 2;
      end else if (pick < 88) begin
        send_beat(KIND_FLUSH, 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_beat(KIND_DATA, 8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    jis_mode  = MODE_ROMAN;
    held_lead = 8'h00;
    lead_held = 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    rst_n    <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_queue_backpressure();
    test_random_stream(415);

    in_valid <= 1'b0;
    while (iso_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
